// ----- hw/rtl/min_max_tracking_stack_defines.svh -----
// Assertion macros for the min/max tracking stack.
// Included by the checker; expects clk and arst_n in the including scope.
`ifndef MIN_MAX_TRACKING_STACK_DEFINES_SVH
`define MIN_MAX_TRACKING_STACK_DEFINES_SVH

// same-cycle implication
`define MMTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmts assertion failed");

// next-cycle implication
`define MMTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmts assertion failed");

`endif

// ----- hw/rtl/mmts_pkg.sv -----
// Shared constants and types for the min/max tracking stack.
// No dependencies; used by every module of the block.
`default_nettype none

package mmts_pkg;

	localparam int ID_W         = 16;
	localparam int PORT_PRICE_W = 32;
	localparam int CNT_PORT_W   = 7;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/min_max_tracking_stack.sv -----
// Top level of the min/max tracking stack: a row of shifting level cells.
// Depends on mmts_pkg, mmts_cell and mmts_ext.
//
// A LIFO of (model_id, price) records in a chain of STACK_DEPTH cells; cell 0
// is the top, and each cell also carries the lowest- and highest-priced record
// at or below it, so every push or pop that changes the stack moves the
// whole row one place at once. One request is taken per clock; its result
// appears in the output register on the next cycle and a new request is
// taken while that result waits, as long as out_ready is high or the register
// is empty. The cycle is set by one signed price compare plus the shift mux of
// each cell. There is no memory and no clearing pass: the block is ready
// right after reset. Ties keep the older extreme. Pop or query on an empty
// stack reports status empty with zero records; a push onto a full stack is
// refused with status full and reports the unchanged top.
`default_nettype none

module min_max_tracking_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int PRICE_BITS  = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [mmts_pkg::OP_W-1:0]               operation,
	input  logic [mmts_pkg::ID_W-1:0]               model_id,
	input  logic signed [mmts_pkg::PORT_PRICE_W-1:0] price,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [mmts_pkg::ID_W-1:0]               removed_id,
	output logic signed [mmts_pkg::PORT_PRICE_W-1:0] removed_price,
	output logic [mmts_pkg::ID_W-1:0]               top_id,
	output logic signed [mmts_pkg::PORT_PRICE_W-1:0] top_price,
	output logic [mmts_pkg::ID_W-1:0]               lowest_id,
	output logic signed [mmts_pkg::PORT_PRICE_W-1:0] lowest_price,
	output logic [mmts_pkg::ID_W-1:0]               highest_id,
	output logic signed [mmts_pkg::PORT_PRICE_W-1:0] highest_price,
	output logic [mmts_pkg::CNT_PORT_W-1:0]         entry_count,
	output logic [mmts_pkg::STATUS_W-1:0]           status
);

	import mmts_pkg::*;

	localparam int REC_W = ID_W + PRICE_BITS;
	localparam int LVL_W = 3 * REC_W;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	// level layout: {rec_id, rec_price, lo_id, lo_price, hi_id, hi_price}
	localparam int REC_ID_HI = LVL_W - 1;
	localparam int REC_PR_HI = LVL_W - ID_W - 1;
	localparam int LO_ID_HI  = 2 * REC_W - 1;
	localparam int LO_PR_HI  = 2 * REC_W - ID_W - 1;
	localparam int HI_ID_HI  = REC_W - 1;
	localparam int HI_PR_HI  = PRICE_BITS - 1;

	logic [LVL_W-1:0] lvl [STACK_DEPTH];
	logic [LVL_W-1:0] push_lvl;
	logic [LVL_W-1:0] view_lvl;
	logic [LVL_W-1:0] view_d;
	logic [REC_W-1:0] removed_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [STATUS_W-1:0] status_d;
	shift_ctl_t shift;
	logic accept;
	logic is_empty;
	logic is_full;

	logic signed [PRICE_BITS-1:0] in_price;
	logic [ID_W-1:0]              new_lo_id;
	logic signed [PRICE_BITS-1:0] new_lo_price;
	logic [ID_W-1:0]              new_hi_id;
	logic signed [PRICE_BITS-1:0] new_hi_price;

	logic                  out_valid_q;
	logic [LVL_W-1:0]      view_q;
	logic [REC_W-1:0]      removed_q;
	logic [CNT_W-1:0]      cnt_out_q;
	logic [STATUS_W-1:0]   status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign in_price = PRICE_BITS'(price);

	mmts_ext #(
		.PRICE_BITS(PRICE_BITS)
	) u_ext (
		.empty        (is_empty),
		.new_id       (model_id),
		.new_price    (in_price),
		.cur_lo_id    (lvl[0][LO_ID_HI -: ID_W]),
		.cur_lo_price (signed'(lvl[0][LO_PR_HI -: PRICE_BITS])),
		.cur_hi_id    (lvl[0][HI_ID_HI -: ID_W]),
		.cur_hi_price (signed'(lvl[0][HI_PR_HI -: PRICE_BITS])),
		.lo_id        (new_lo_id),
		.lo_price     (new_lo_price),
		.hi_id        (new_hi_id),
		.hi_price     (new_hi_price)
	);

	assign push_lvl = {model_id, in_price, new_lo_id, new_lo_price, new_hi_id, new_hi_price};

	always_comb begin
		shift     = '0;
		status_d  = STATUS_OK;
		count_d   = count_q;
		view_lvl  = lvl[0];
		removed_d = '0;
		case (operation)
			OP_PUSH: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					shift.push = accept;
					count_d    = count_q + 1'b1;
					view_lvl   = push_lvl;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					shift.pop = accept;
					count_d   = count_q - 1'b1;
					view_lvl  = lvl[1];
					removed_d = lvl[0][REC_ID_HI -: REC_W];
				end
			end
			OP_QUERY: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end
			end
			default: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end
			end
		endcase
		view_d = (count_d == '0) ? '0 : view_lvl;
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [LVL_W-1:0] above;
		logic [LVL_W-1:0] below;
		if (i == 0) begin : g_head
			assign above = push_lvl;
		end else begin : g_mid_a
			assign above = lvl[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign below = lvl[i];
		end else begin : g_mid_b
			assign below = lvl[i+1];
		end
		mmts_cell #(
			.W(LVL_W)
		) u_cell (
			.clk        (clk),
			.ctl        (shift),
			.from_above (above),
			.from_below (below),
			.level      (lvl[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			view_q    <= view_d;
			removed_q <= removed_d;
			cnt_out_q <= count_d;
			status_q  <= status_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_id    = removed_q[REC_W-1 -: ID_W];
	assign removed_price = PORT_PRICE_W'(signed'(removed_q[PRICE_BITS-1:0]));
	assign top_id        = view_q[REC_ID_HI -: ID_W];
	assign top_price     = PORT_PRICE_W'(signed'(view_q[REC_PR_HI -: PRICE_BITS]));
	assign lowest_id     = view_q[LO_ID_HI -: ID_W];
	assign lowest_price  = PORT_PRICE_W'(signed'(view_q[LO_PR_HI -: PRICE_BITS]));
	assign highest_id    = view_q[HI_ID_HI -: ID_W];
	assign highest_price = PORT_PRICE_W'(signed'(view_q[HI_PR_HI -: PRICE_BITS]));
	assign entry_count   = CNT_PORT_W'(cnt_out_q);
	assign status        = status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mmts_cell.sv -----
// One stack level: record plus running low and high, shifted as a unit.
// Depends on mmts_pkg for the shift control struct.
`default_nettype none

module mmts_cell #(
	parameter int W = 8
) (
	input  logic                 clk,
	input  mmts_pkg::shift_ctl_t ctl,
	input  logic [W-1:0]         from_above,
	input  logic [W-1:0]         from_below,
	output logic [W-1:0]         level
);

	logic [W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			level_q <= from_above;
		end else if (ctl.pop) begin
			level_q <= from_below;
		end
	end

	assign level = level_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mmts_ext.sv -----
// Extreme update for a push: new low and high from the current top level.
// Depends on mmts_pkg for the id width.
`default_nettype none

module mmts_ext #(
	parameter int PRICE_BITS = 32
) (
	input  logic                          empty,
	input  logic [mmts_pkg::ID_W-1:0]     new_id,
	input  logic signed [PRICE_BITS-1:0]  new_price,
	input  logic [mmts_pkg::ID_W-1:0]     cur_lo_id,
	input  logic signed [PRICE_BITS-1:0]  cur_lo_price,
	input  logic [mmts_pkg::ID_W-1:0]     cur_hi_id,
	input  logic signed [PRICE_BITS-1:0]  cur_hi_price,
	output logic [mmts_pkg::ID_W-1:0]     lo_id,
	output logic signed [PRICE_BITS-1:0]  lo_price,
	output logic [mmts_pkg::ID_W-1:0]     hi_id,
	output logic signed [PRICE_BITS-1:0]  hi_price
);

	always_comb begin
		lo_id    = cur_lo_id;
		lo_price = cur_lo_price;
		hi_id    = cur_hi_id;
		hi_price = cur_hi_price;
		if (empty) begin
			lo_id    = new_id;
			lo_price = new_price;
			hi_id    = new_id;
			hi_price = new_price;
		end else if (new_price < cur_lo_price) begin
			lo_id    = new_id;
			lo_price = new_price;
		end else if (new_price > cur_hi_price) begin
			hi_id    = new_id;
			hi_price = new_price;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mmts_checker.sv -----
// Port-level checks for the min/max tracking stack, bound to the top level.
// Depends on mmts_pkg and min_max_tracking_stack_defines.svh.
`default_nettype none

`include "min_max_tracking_stack_defines.svh"

module mmts_checker #(
	parameter int STACK_DEPTH = 64
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [mmts_pkg::ID_W-1:0]         top_id,
	input logic [mmts_pkg::PORT_PRICE_W-1:0] top_price,
	input logic [mmts_pkg::ID_W-1:0]         lowest_id,
	input logic [mmts_pkg::PORT_PRICE_W-1:0] highest_price,
	input logic [mmts_pkg::CNT_PORT_W-1:0]   entry_count,
	input logic [mmts_pkg::STATUS_W-1:0]     status
);

	import mmts_pkg::*;

	// a held result stays valid and keeps its count and status
	`MMTS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(entry_count) && $stable(status))

	// every request yields a result on the next cycle
	`MMTS_ASSERT_NEXT(a_resp, in_valid && in_ready, out_valid)

	// empty status reports an empty stack with zero records
	`MMTS_ASSERT_NOW(a_empty, out_valid && status == STATUS_EMPTY, entry_count == '0 && top_id == '0 && top_price == '0 && lowest_id == '0 && highest_price == '0)

	// full status only at capacity
	`MMTS_ASSERT_NOW(a_full, out_valid && status == STATUS_FULL, entry_count == CNT_PORT_W'(STACK_DEPTH))

endmodule

bind min_max_tracking_stack mmts_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_mmts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.top_id        (top_id),
	.top_price     (top_price),
	.lowest_id     (lowest_id),
	.highest_price (highest_price),
	.entry_count   (entry_count),
	.status        (status)
);

`default_nettype wire

// ----- tb/sv/min_max_tracking_stack_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the min/max tracking stack: predicts every result and compares it.
// Depends on mmts_pkg; instanced by min_max_tracking_stack_tb beside the block.
module min_max_tracking_stack_checker
	import mmts_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [OP_W-1:0]                operation,
	input  logic [ID_W-1:0]                model_id,
	input  logic signed [PORT_PRICE_W-1:0] price,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [ID_W-1:0]                removed_id,
	input  logic signed [PORT_PRICE_W-1:0] removed_price,
	input  logic [ID_W-1:0]                top_id,
	input  logic signed [PORT_PRICE_W-1:0] top_price,
	input  logic [ID_W-1:0]                lowest_id,
	input  logic signed [PORT_PRICE_W-1:0] lowest_price,
	input  logic [ID_W-1:0]                highest_id,
	input  logic signed [PORT_PRICE_W-1:0] highest_price,
	input  logic [CNT_PORT_W-1:0]          entry_count,
	input  logic [STATUS_W-1:0]            status,
	output int                             mismatches,
	output int                             pending
);

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic [PORT_PRICE_W-1:0] price;
	} price_rec_t;

	typedef struct packed {
		price_rec_t              removed;
		price_rec_t              top;
		price_rec_t              lowest;
		price_rec_t              highest;
		logic [CNT_PORT_W-1:0]   count;
		logic [STATUS_W-1:0]     status;
	} stack_view_t;

	price_rec_t  record_level  [STACK_DEPTH];
	price_rec_t  lowest_level  [STACK_DEPTH];
	price_rec_t  highest_level [STACK_DEPTH];
	int          fill = 0;
	int          errs = 0;
	stack_view_t view_q[$];

	function automatic stack_view_t apply_request(logic [OP_W-1:0] op, price_rec_t req);
		stack_view_t v;
		price_rec_t  lo;
		price_rec_t  hi;
		v = '0;
		if (op == OP_PUSH) begin
			if (fill == STACK_DEPTH) begin
				v.status = STATUS_FULL;
			end else begin
				lo = req;
				hi = req;
				if (fill > 0) begin
					lo = lowest_level[fill-1];
					hi = highest_level[fill-1];
					// ties keep the older record
					if ($signed(req.price) < $signed(lo.price))
						lo = req;
					else if ($signed(req.price) > $signed(hi.price))
						hi = req;
				end
				record_level[fill]  = req;
				lowest_level[fill]  = lo;
				highest_level[fill] = hi;
				fill++;
			end
		end else if (op == OP_POP) begin
			if (fill == 0) begin
				v.status = STATUS_EMPTY;
			end else begin
				fill--;
				v.removed = record_level[fill];
			end
		end else if (fill == 0) begin
			v.status = STATUS_EMPTY;
		end
		if (fill > 0) begin
			v.top     = record_level[fill-1];
			v.lowest  = lowest_level[fill-1];
			v.highest = highest_level[fill-1];
		end
		v.count = CNT_PORT_W'(fill);
		return v;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errs++;
			if (errs <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_view_t want;
		price_rec_t  req;
		if (!arst_n) begin
			fill = 0;
			view_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (view_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result: count %0d, status %0d", entry_count, status);
				end else begin
					want = view_q.pop_front();
					check_field("removed_id",    32'(want.removed.id),    32'(removed_id));
					check_field("removed_price", want.removed.price,      removed_price);
					check_field("top_id",        32'(want.top.id),        32'(top_id));
					check_field("top_price",     want.top.price,          top_price);
					check_field("lowest_id",     32'(want.lowest.id),     32'(lowest_id));
					check_field("lowest_price",  want.lowest.price,       lowest_price);
					check_field("highest_id",    32'(want.highest.id),    32'(highest_id));
					check_field("highest_price", want.highest.price,      highest_price);
					check_field("entry_count",   32'(want.count),         32'(entry_count));
					check_field("status",        32'(want.status),        32'(status));
				end
			end
			if (in_valid && in_ready) begin
				req.id    = model_id;
				req.price = price;
				view_q.push_back(apply_request(operation, req));
			end
		end
		mismatches <= errs;
		pending    <= view_q.size();
	end

endmodule

// ----- tb/sv/min_max_tracking_stack_tb.sv -----
`timescale 1ns / 1ps
// Top of the min/max tracking stack testbench: clock, reset, requests and verdict.
// Depends on mmts_pkg, min_max_tracking_stack and min_max_tracking_stack_checker.
module min_max_tracking_stack_tb;
	import mmts_pkg::*;

	localparam int STACK_DEPTH    = 64;
	localparam int RANDOM_REQS    = 1130;
	localparam int CALM_TAIL      = 150;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [OP_W-1:0]                operation = OP_QUERY;
	logic [ID_W-1:0]                model_id  = '0;
	logic signed [PORT_PRICE_W-1:0] price     = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [ID_W-1:0]                removed_id;
	logic signed [PORT_PRICE_W-1:0] removed_price;
	logic [ID_W-1:0]                top_id;
	logic signed [PORT_PRICE_W-1:0] top_price;
	logic [ID_W-1:0]                lowest_id;
	logic signed [PORT_PRICE_W-1:0] lowest_price;
	logic [ID_W-1:0]                highest_id;
	logic signed [PORT_PRICE_W-1:0] highest_price;
	logic [CNT_PORT_W-1:0]          entry_count;
	logic [STATUS_W-1:0]            status;

	int   mismatches;
	int   pending;
	int   quiet_cycles = 0;
	logic calm         = 1'b0;
	logic hold_req     = 1'b0;
	logic hold_done    = 1'b0;

	min_max_tracking_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.model_id     (model_id),
		.price        (price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_id   (removed_id),
		.removed_price(removed_price),
		.top_id       (top_id),
		.top_price    (top_price),
		.lowest_id    (lowest_id),
		.lowest_price (lowest_price),
		.highest_id   (highest_id),
		.highest_price(highest_price),
		.entry_count  (entry_count),
		.status       (status)
	);

	min_max_tracking_stack_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.model_id     (model_id),
		.price        (price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_id   (removed_id),
		.removed_price(removed_price),
		.top_id       (top_id),
		.top_price    (top_price),
		.lowest_id    (lowest_id),
		.lowest_price (lowest_price),
		.highest_id   (highest_id),
		.highest_price(highest_price),
		.entry_count  (entry_count),
		.status       (status),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	function automatic logic [PORT_PRICE_W-1:0] pick_price();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 6) - 3;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [PORT_PRICE_W-1:0] pr);
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		model_id  <= id;
		price     <= pr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// request side
	initial begin
		int               sent;
		int               phase;
		int               len;
		int               push_pct;
		int               r;
		mix_t             mix;
		logic [OP_W-1:0]  op;
		sent  = 0;
		phase = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, spare code, extremes and ties
		send_req(OP_QUERY, 16'h1234, 32'h0000_0005);
		send_req(OP_POP,   16'hFFFF, 32'hFFFF_FFFF);
		send_req(OP_SPARE, 16'h0000, 32'h0000_0000);
		send_req(OP_PUSH,  16'hFFFF, 32'h7FFF_FFFF);
		send_req(OP_PUSH,  16'h0000, 32'h8000_0000);
		send_req(OP_PUSH,  16'h0001, 32'h8000_0000);
		send_req(OP_PUSH,  16'h0002, 32'h7FFF_FFFF);
		send_req(OP_PUSH,  16'h0003, 32'h0000_0000);
		send_req(OP_PUSH,  16'h0004, 32'hFFFF_FFFF);
		send_req(OP_QUERY, 16'hAAAA, 32'h5555_5555);
		send_req(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
		repeat (7) send_req(OP_POP, ID_W'($urandom_range(0, 65535)), $urandom());
		send_req(OP_PUSH,  16'h8000, 32'h0000_0001);
		send_req(OP_PUSH,  16'h7FFF, 32'hFFFF_FFFE);
		send_req(OP_PUSH,  16'h0005, 32'h0000_0002);
		send_req(OP_POP,   16'h5555, 32'hAAAA_AAAA);
		send_req(OP_POP,   16'h0000, 32'h0000_0000);

		while (sent < RANDOM_REQS) begin
			if (phase == 0)
				mix = MIX_FILL;
			else if (phase == 1)
				mix = MIX_DRAIN;
			else
				mix = mix_t'($urandom_range(0, 4));
			case (mix)
				MIX_FILL:   begin push_pct = 100; len = 90; end
				MIX_DRAIN:  begin push_pct = 0;   len = 90; end
				MIX_GROW:   begin push_pct = 70;  len = $urandom_range(20, 80); end
				MIX_SHRINK: begin push_pct = 25;  len = $urandom_range(20, 80); end
				default:    begin push_pct = 50;  len = $urandom_range(20, 80); end
			endcase
			for (int k = 0; k < len && sent < RANDOM_REQS; k++) begin
				calm = (sent >= RANDOM_REQS - CALM_TAIL);
				if (sent == HOLD_AT)
					hold_req <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 3)
					op = OP_SPARE;
				else if (r < 12)
					op = OP_QUERY;
				else if ($urandom_range(0, 99) < push_pct)
					op = OP_PUSH;
				else
					op = OP_POP;
				send_req(op, ID_W'($urandom_range(0, 65535)), pick_price());
				sent++;
			end
			phase++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// result side
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
